// ----- hw/rtl/pid_with_clamped_terms_assert.svh -----
// Assertion macros shared by the PID checker.
`ifndef PID_WITH_CLAMPED_TERMS_ASSERT_SVH
`define PID_WITH_CLAMPED_TERMS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PIDCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidct check failed");

// Next-cycle implication, disabled while reset is low.
`define PIDCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidct check failed");

// Implication that is also checked during reset.
`define PIDCT_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("pidct check failed");

`endif

// ----- hw/rtl/pidct_pkg.sv -----
// Package: types, register codes and helpers for the PID block.
`timescale 1ns / 1ps

package pidct_pkg;

  localparam int unsigned GAIN_W    = 18;
  localparam int unsigned PLIM_W    = 23;
  localparam int unsigned ILIM_W    = 31;
  localparam int unsigned DLIM_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 31;
  localparam int unsigned TERM_W    = 32;
  localparam int unsigned INTEG_W   = 32;
  localparam int unsigned WIDE_W    = 34;

  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P_ERROR_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_D_DIFF_LIMIT   = 3'd5;

  // common width for clamps and the final sum
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [TERM_W-1:0] term_t;

  localparam wide_t S32_MAX_W = 34'sd2147483647;
  localparam wide_t S32_MIN_W = -34'sd2147483648;

  // symmetric clamp to +/- lim (lim is non-negative)
  function automatic wide_t clamp_sym(input wide_t x, input wide_t lim);
    wide_t r;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end else begin
      r = x;
    end
    return r;
  endfunction

  function automatic term_t sat32(input wide_t x);
    wide_t r;
    if (x > S32_MAX_W) begin
      r = S32_MAX_W;
    end else if (x < S32_MIN_W) begin
      r = S32_MIN_W;
    end else begin
      r = x;
    end
    return r[TERM_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/pidct_in_if.sv -----
// Input channel: action and error sample with valid/ready.
`timescale 1ns / 1ps

interface pidct_in_if #(
  parameter int unsigned ERROR_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic signed [ERROR_WIDTH-1:0] error_value;

  modport source (output valid, action, error_value, input ready);
  modport sink   (input valid, action, error_value, output ready);
  modport monitor (input valid, ready, action, error_value);
endinterface

// ----- hw/rtl/pidct_out_if.sv -----
// Output channel: command and the three terms with valid/ready.
`timescale 1ns / 1ps

interface pidct_out_if;
  logic                 valid;
  logic                 ready;
  pidct_pkg::term_t     command;
  pidct_pkg::term_t     p_term;
  pidct_pkg::term_t     i_term;
  pidct_pkg::term_t     d_term;

  modport source (output valid, command, p_term, i_term, d_term, input ready);
  modport sink   (input valid, command, p_term, i_term, d_term, output ready);
  modport monitor (input valid, ready, command, p_term, i_term, d_term);
endinterface

// ----- hw/rtl/pidct_term.sv -----
// One PID term: clamped value times gain, floor shift, saturate to 32 bits.
`timescale 1ns / 1ps

module pidct_term #(
  parameter int unsigned W              = 24,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic signed [W-1:0]                value_i,
  input  logic [pidct_pkg::GAIN_W-1:0]       gain_i,
  output pidct_pkg::term_t                   term_o
);

  localparam int unsigned PW = W + pidct_pkg::GAIN_W + 1;

  localparam logic signed [63:0] MAX_V = 64'sd2147483647;
  localparam logic signed [63:0] MIN_V = -64'sd2147483648;

  logic signed [PW-1:0] val_ext;
  logic signed [PW-1:0] gain_ext;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shr;
  logic signed [63:0]   shr_wide;

  assign val_ext  = PW'(value_i);
  assign gain_ext = PW'($signed({1'b0, gain_i}));
  assign prod     = val_ext * gain_ext;
  // arithmetic shift gives floor toward minus infinity
  assign shr      = prod >>> GAIN_FRAC_BITS;
  assign shr_wide = 64'(shr);

  always_comb begin
    if (shr_wide > MAX_V) begin
      term_o = MAX_V[31:0];
    end else if (shr_wide < MIN_V) begin
      term_o = MIN_V[31:0];
    end else begin
      term_o = shr_wide[31:0];
    end
  end

endmodule

// ----- hw/rtl/pid_with_clamped_terms.sv -----
// Top level: PID corrector with clamped P, I and D terms and anti-windup.
//
//   channel  dir  beat contents                          handshake
//   in_i     in   action, error_value (Q8.16 signed)     valid/ready
//   out_o    out  command, p_term, i_term, d_term        valid/ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                 cfg_we_i, no wait
//
// One beat per cycle sustained while the output is not stalled. A beat is
// held in the input register, then the clamps, the three multipliers and
// the saturated sum settle into the output register that offers the result.
// The integral and previous-error registers update as the beat leaves the
// input register. A reset-action beat updates state and emits nothing.
// Reset clears gains, limits, integral and previous error. A stalled output
// holds the input register; reset-action beats still pass a stalled output.
`timescale 1ns / 1ps

module pid_with_clamped_terms #(
  parameter int unsigned ERROR_WIDTH    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pidct_in_if.sink                            in_i,
  pidct_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [pidct_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pidct_pkg::CFG_DAT_W-1:0]     cfg_wdata_i
);

  localparam int unsigned EW = ERROR_WIDTH;

  // configuration registers
  logic [pidct_pkg::GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic [pidct_pkg::PLIM_W-1:0] plim_q;
  logic [pidct_pkg::ILIM_W-1:0] ilim_q;
  logic [pidct_pkg::DLIM_W-1:0] dlim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      plim_q <= '0;
      ilim_q <= '0;
      dlim_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidct_pkg::REG_KP_GAIN:        kp_q   <= cfg_wdata_i[pidct_pkg::GAIN_W-1:0];
        pidct_pkg::REG_KI_GAIN:        ki_q   <= cfg_wdata_i[pidct_pkg::GAIN_W-1:0];
        pidct_pkg::REG_KD_GAIN:        kd_q   <= cfg_wdata_i[pidct_pkg::GAIN_W-1:0];
        pidct_pkg::REG_P_ERROR_LIMIT:  plim_q <= cfg_wdata_i[pidct_pkg::PLIM_W-1:0];
        pidct_pkg::REG_INTEGRAL_LIMIT: ilim_q <= cfg_wdata_i[pidct_pkg::ILIM_W-1:0];
        pidct_pkg::REG_D_DIFF_LIMIT:   dlim_q <= cfg_wdata_i[pidct_pkg::DLIM_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // input register
  logic                 in_vld_q, in_vld_d;
  logic                 in_act_q;
  logic signed [EW-1:0] in_err_q;
  logic                 advance;
  logic                 in_fire;

  // output register
  logic             out_vld_q, out_vld_d;
  pidct_pkg::term_t cmd_q, pt_q, it_q, dt_q;

  // controller state
  logic signed [pidct_pkg::INTEG_W-1:0] integ_q, integ_d;
  logic signed [EW-1:0]                 prev_q, prev_d;

  // reset-action beats never need the output register
  assign advance     = in_vld_q && (in_act_q || !out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_act_q <= in_i.action;
      in_err_q <= in_i.error_value;
    end
  end

  // clamps, all in the common wide format
  pidct_pkg::wide_t e_w, p_c, i_sum, i_c, d_diff, d_c, sum_w;
  logic signed [EW-1:0] p_val;
  logic signed [EW:0]   d_val;
  pidct_pkg::term_t     pt, it, dt, cmd;

  assign e_w    = pidct_pkg::wide_t'(in_err_q);
  assign p_c    = pidct_pkg::clamp_sym(e_w, pidct_pkg::wide_t'(plim_q));
  assign i_sum  = pidct_pkg::wide_t'(integ_q) + e_w;
  assign i_c    = pidct_pkg::clamp_sym(i_sum, pidct_pkg::wide_t'(ilim_q));
  assign d_diff = e_w - pidct_pkg::wide_t'(prev_q);
  assign d_c    = pidct_pkg::clamp_sym(d_diff, pidct_pkg::wide_t'(dlim_q));

  // clamped magnitudes never exceed the unclamped ones
  assign p_val = p_c[EW-1:0];
  assign d_val = d_c[EW:0];

  pidct_term #(.W(EW), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_p_term (
    .value_i (p_val),
    .gain_i  (kp_q),
    .term_o  (pt)
  );

  pidct_term #(.W(pidct_pkg::INTEG_W), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_i_term (
    .value_i (i_c[pidct_pkg::INTEG_W-1:0]),
    .gain_i  (ki_q),
    .term_o  (it)
  );

  pidct_term #(.W(EW + 1), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_d_term (
    .value_i (d_val),
    .gain_i  (kd_q),
    .term_o  (dt)
  );

  assign sum_w = pidct_pkg::wide_t'(pt) + pidct_pkg::wide_t'(it) + pidct_pkg::wide_t'(dt);
  assign cmd   = pidct_pkg::sat32(sum_w);

  // state update as the beat leaves the input register
  always_comb begin
    integ_d = integ_q;
    prev_d  = prev_q;
    if (advance) begin
      prev_d = in_err_q;
      if (in_act_q) begin
        integ_d = '0;
      end else begin
        integ_d = i_c[pidct_pkg::INTEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && !in_act_q) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !in_act_q) begin
      cmd_q <= cmd;
      pt_q  <= pt;
      it_q  <= it;
      dt_q  <= dt;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.command = cmd_q;
  assign out_o.p_term  = pt_q;
  assign out_o.i_term  = it_q;
  assign out_o.d_term  = dt_q;

endmodule

// ----- hw/rtl/pidct_chk.sv -----
// Port-level checker for the PID block, bound to the top level.
`timescale 1ns / 1ps
`include "pid_with_clamped_terms_assert.svh"

module pidct_chk (
  input logic          clk_i,
  input logic          rst_ni,
  pidct_in_if.sink     in_i,
  pidct_out_if.source  out_o
);

  // no result once reset has been seen low for a full cycle
  `PIDCT_ASSERT_RST(a_rst_quiet, clk_i, !rst_ni && $past(!rst_ni), !out_o.valid)

  // input only backs up behind a stalled result
  `PIDCT_ASSERT_IMP(a_bp_cause, clk_i, rst_ni, !in_i.ready, out_o.valid && !out_o.ready)

  // a control beat followed by a free output yields a result
  `PIDCT_ASSERT_NXT(a_result_due, clk_i, rst_ni,
    in_i.valid && in_i.ready && !in_i.action ##1 out_o.ready, out_o.valid)

  // stalled result holds
  `PIDCT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready,
    out_o.valid && $stable(out_o.command) && $stable(out_o.p_term) && $stable(out_o.i_term) && $stable(out_o.d_term))

endmodule

bind pid_with_clamped_terms pidct_chk u_pidct_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

// ----- tb/sv/pidct_tb_pkg.sv -----
// Testbench constants for the PID corrector: beat action codes and an unmapped register index.
`timescale 1ns / 1ps

package pidct_tb_pkg;

  typedef enum logic {
    ACT_STEP  = 1'b0,
    ACT_CLEAR = 1'b1
  } pid_action_e;

  // no register lives here; writes to it must be dropped
  localparam logic [pidct_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

endpackage

// ----- tb/sv/pid_term_checker.sv -----
// Checker for the PID corrector: predicts the four output terms and compares every result beat.
`timescale 1ns / 1ps

module pid_term_checker
  import pidct_pkg::*, pidct_tb_pkg::*;
#(
  parameter int unsigned ERROR_WIDTH    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pidct_in_if.monitor          in_mon,
  pidct_out_if.monitor         out_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   compared_o
);

  localparam int     MAX_REPORTS = 10;
  localparam longint TERM_MAX    = 64'sd2147483647;
  localparam longint TERM_MIN    = -64'sd2147483648;

  typedef struct packed {
    term_t command;
    term_t p_term;
    term_t i_term;
    term_t d_term;
  } pid_terms_t;

  longint     kp_gain, ki_gain, kd_gain;
  longint     p_err_lim, integ_lim, d_diff_lim;
  longint     integ_acc, last_error;
  pid_terms_t terms_q[$];

  function automatic term_t saturate(input longint v);
    longint r;
    r = (v > TERM_MAX) ? TERM_MAX : ((v < TERM_MIN) ? TERM_MIN : v);
    return term_t'(r);
  endfunction

  function automatic longint bound(input longint v, input longint lim);
    if (v > lim) begin
      return lim;
    end
    if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // arithmetic shift of a signed product floors toward minus infinity
  function automatic term_t scaled(input longint v, input longint gain);
    return saturate((v * gain) >>> GAIN_FRAC_BITS);
  endfunction

  // one control step; updates the integral and the held error
  function automatic pid_terms_t step_terms(input longint err);
    pid_terms_t t;
    term_t      pt, it, dt;
    pt         = scaled(bound(err, p_err_lim), kp_gain);
    integ_acc  = bound(integ_acc + err, integ_lim);
    it         = scaled(integ_acc, ki_gain);
    dt         = scaled(bound(err - last_error, d_diff_lim), kd_gain);
    last_error = err;
    t.p_term   = pt;
    t.i_term   = it;
    t.d_term   = dt;
    t.command  = saturate(longint'(pt) + longint'(it) + longint'(dt));
    return t;
  endfunction

  function automatic bit note_failure();
    fail_count_o++;
    return fail_count_o <= MAX_REPORTS;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pid_terms_t got, want;
    longint     err;
    if (!rst_ni) begin
      kp_gain      = 0;
      ki_gain      = 0;
      kd_gain      = 0;
      p_err_lim    = 0;
      integ_lim    = 0;
      d_diff_lim   = 0;
      integ_acc    = 0;
      last_error   = 0;
      terms_q.delete();
      fail_count_o = 0;
      compared_o   = 0;
      pending_o   <= 0;
    end else begin
      // result side first: a result leaving now belongs to an older beat
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.command, out_mon.p_term, out_mon.i_term, out_mon.d_term};
        if (terms_q.size() == 0) begin
          if (note_failure()) begin
            $display("%0t: result beat with nothing outstanding: cmd=%0d p=%0d i=%0d d=%0d",
                     $time, $signed(got.command), $signed(got.p_term),
                     $signed(got.i_term), $signed(got.d_term));
          end
        end else begin
          want = terms_q.pop_front();
          compared_o++;
          if (got != want) begin
            if (note_failure()) begin
              $display("%0t: result %0d mismatch", $time, compared_o);
              $display("  expected cmd=%0d p=%0d i=%0d d=%0d", $signed(want.command),
                       $signed(want.p_term), $signed(want.i_term), $signed(want.d_term));
              $display("  actual   cmd=%0d p=%0d i=%0d d=%0d", $signed(got.command),
                       $signed(got.p_term), $signed(got.i_term), $signed(got.d_term));
            end
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        err = longint'(in_mon.error_value);
        if (in_mon.action == ACT_CLEAR) begin
          integ_acc  = 0;
          last_error = err;
        end else begin
          terms_q.push_back(step_terms(err));
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP_GAIN:        kp_gain    = longint'(cfg_wdata_i[GAIN_W-1:0]);
          REG_KI_GAIN:        ki_gain    = longint'(cfg_wdata_i[GAIN_W-1:0]);
          REG_KD_GAIN:        kd_gain    = longint'(cfg_wdata_i[GAIN_W-1:0]);
          REG_P_ERROR_LIMIT:  p_err_lim  = longint'(cfg_wdata_i[PLIM_W-1:0]);
          REG_INTEGRAL_LIMIT: integ_lim  = longint'(cfg_wdata_i[ILIM_W-1:0]);
          REG_D_DIFF_LIMIT:   d_diff_lim = longint'(cfg_wdata_i[DLIM_W-1:0]);
          default: ;
        endcase
      end

      pending_o <= terms_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_pid_with_clamped_terms.sv -----
// Testbench top for the PID corrector: stimulus, traffic shaping, register settings and verdict.
`timescale 1ns / 1ps

module tb_pid_with_clamped_terms;
  import pidct_pkg::*;
  import pidct_tb_pkg::*;

  localparam int unsigned ERROR_WIDTH     = 24;
  localparam int unsigned GAIN_FRAC_BITS  = 12;
  // result passes the input and output registers; give reset-action beats room
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned LONG_HOLD       = 200;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned BEATS_PER_PHASE = 75;
  localparam int unsigned PRESSURE_PHASE  = 4;
  localparam int unsigned CLEAR_PCT       = 6;
  localparam int unsigned RUN_LIMIT_NS    = 5_000_000;

  localparam logic [CFG_DAT_W-1:0] ALL_ONES   = '1;
  localparam logic [CFG_DAT_W-1:0] GAIN_MAX   = ALL_ONES >> (CFG_DAT_W - GAIN_W);
  localparam logic [CFG_DAT_W-1:0] PLIM_MAX   = ALL_ONES >> (CFG_DAT_W - PLIM_W);
  localparam logic [CFG_DAT_W-1:0] ILIM_MAX   = ALL_ONES >> (CFG_DAT_W - ILIM_W);
  localparam logic [CFG_DAT_W-1:0] DLIM_MAX   = ALL_ONES >> (CFG_DAT_W - DLIM_W);
  localparam logic [CFG_DAT_W-1:0] UNITY_GAIN = CFG_DAT_W'(1 << GAIN_FRAC_BITS);

  localparam logic signed [ERROR_WIDTH-1:0] ERR_MAX = {1'b0, {(ERROR_WIDTH-1){1'b1}}};
  localparam logic signed [ERROR_WIDTH-1:0] ERR_MIN = {1'b1, {(ERROR_WIDTH-1){1'b0}}};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  pidct_in_if #(.ERROR_WIDTH(ERROR_WIDTH)) in_ch ();
  pidct_out_if                             out_ch ();

  // traffic knobs, percent of cycles spent idle or stalled
  int send_idle_pct;
  int recv_stall_pct;
  // bumped by the stimulus to ask the sink for one long hold-off
  int hold_requests;

  int fail_count;
  int pending;
  int compared;
  int beats_sent;
  int clears_sent;
  int settings_used;

  pid_with_clamped_terms #(
    .ERROR_WIDTH   (ERROR_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  pid_term_checker #(
    .ERROR_WIDTH   (ERROR_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .compared_o  (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a result never shows up or the input never frees.
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result sink. Normally stalls at random per recv_stall_pct; on request it
  // drops ready for a long fixed stretch so the block backs up into its input.
  initial begin : sink_side
    int hold_done;
    int n;
    hold_done    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_done) begin
        hold_done = hold_requests;
        out_ch.ready <= 1'b0;
        for (n = 1; n < LONG_HOLD; n++) begin
          @(posedge clk);
        end
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one beat, with random idle cycles in front per send_idle_pct.
  // valid stays high across back-to-back beats.
  task automatic send_beat(input pid_action_e act,
                           input logic signed [ERROR_WIDTH-1:0] err);
    logic rdy;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.error_value <= err;
    // all drives move on the rising edge, so ready seen at the falling edge
    // is what the next rising edge samples
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    beats_sent++;
    if (act == ACT_CLEAR) begin
      clears_sent++;
    end
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe go
  // quiet so a register write cannot land on a beat still in flight.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all six registers back to back, plus a junk write to an unmapped
  // index that the block has to drop.
  task automatic apply_settings(input logic [CFG_DAT_W-1:0] kp, ki, kd,
                                input logic [CFG_DAT_W-1:0] plim, ilim, dlim);
    logic [CFG_IDX_W-1:0] idx_list [7];
    logic [CFG_DAT_W-1:0] data_list [7];
    idx_list  = '{REG_KP_GAIN, REG_KI_GAIN, REG_KD_GAIN, REG_P_ERROR_LIMIT,
                  REG_INTEGRAL_LIMIT, REG_D_DIFF_LIMIT, REG_UNMAPPED};
    data_list = '{kp, ki, kd, plim, ilim, dlim, CFG_DAT_W'($urandom())};
    for (int k = 0; k < 7; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx_list[k];
      cfg_wdata <= data_list[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Register value: zero, full scale, small (around unity gain) or anything.
  function automatic logic [CFG_DAT_W-1:0] pick_reg(input int unsigned width);
    logic [CFG_DAT_W-1:0] full;
    full = ALL_ONES >> (CFG_DAT_W - width);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return full;
      2:       return CFG_DAT_W'($urandom_range(0, 2 * UNITY_GAIN));
      default: return CFG_DAT_W'($urandom()) & full;
    endcase
  endfunction

  // Error sample. A nonzero lean pushes most samples to one sign so the
  // integral winds up into its bound and the I term can saturate.
  function automatic logic signed [ERROR_WIDTH-1:0] pick_error(input int lean);
    logic signed [ERROR_WIDTH-1:0] e;
    case ($urandom_range(0, 9))
      0:       e = ERR_MAX;
      1:       e = ERR_MIN;
      2, 3:    e = ERROR_WIDTH'(int'($urandom_range(0, 511)) - 256);
      default: e = ERROR_WIDTH'($urandom());
    endcase
    if ($urandom_range(0, 9) < 8) begin
      if ((lean > 0 && e < 0) || (lean < 0 && e >= 0)) begin
        e = ~e;
      end
    end
    return e;
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int          lean;

    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_STEP;
    in_ch.error_value = '0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_requests     = 0;
    beats_sent        = 0;
    clears_sent       = 0;
    settings_used     = 0;

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // Registers still at reset: zero gains and zero limits, so every term is
    // zero and the integral is pinned at zero.
    send_beat(ACT_STEP, ERR_MAX);
    send_beat(ACT_STEP, ERR_MIN);
    settle();

    // Everything at full scale. Preload the most negative error, then jump to
    // the most positive: the difference is exactly the widest D bound.
    apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, PLIM_MAX, ILIM_MAX, DLIM_MAX);
    send_beat(ACT_CLEAR, ERR_MIN);
    send_beat(ACT_STEP, ERR_MAX);
    send_beat(ACT_STEP, ERR_MIN);
    send_beat(ACT_STEP, '0);
    // -1 times a fractional gain must floor, not truncate toward zero
    send_beat(ACT_STEP, -1);
    send_beat(ACT_STEP, 1);
    send_beat(ACT_CLEAR, '0);
    // integral winds up; the sum of terms runs past the 32-bit range
    repeat (4) send_beat(ACT_STEP, ERR_MAX);
    settle();

    // Zero P and D limits kill those terms; zero I gain with a live limit:
    // the integral keeps accumulating and clamping behind a zero term.
    apply_settings(UNITY_GAIN, '0, UNITY_GAIN, '0, 1000, '0);
    send_beat(ACT_STEP, 5000);
    send_beat(ACT_STEP, -3);
    send_beat(ACT_STEP, 2000);
    settle();

    // Shrink the integral bound under a wound-up integral, no clear: the
    // next step must pull it into the new bound.
    apply_settings(UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, 300, 100, 50);
    send_beat(ACT_STEP, '0);
    send_beat(ACT_STEP, -5000);

    // ---- random ----
    // Each phase: fresh register setting, its own traffic shape and sign lean.
    // Mostly control steps, now and then an integral clear with a preload.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, PLIM_MAX, ILIM_MAX, DLIM_MAX);
      end else begin
        apply_settings(pick_reg(GAIN_W), pick_reg(GAIN_W), pick_reg(GAIN_W),
                       pick_reg(PLIM_W), pick_reg(ILIM_W), pick_reg(DLIM_W));
      end

      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase

      // back-pressure: sink goes dark while the source keeps offering
      if (phase == PRESSURE_PHASE) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests <= hold_requests + 1;
      end

      lean = int'($urandom_range(0, 2)) - 1;
      for (n = 0; n < BEATS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < CLEAR_PCT) begin
          send_beat(ACT_CLEAR, pick_error(0));
        end else begin
          send_beat(ACT_STEP, pick_error(lean));
        end
      end
    end

    settle();

    $display("Covered %0d input beats (%0d integral clears) over %0d register settings;",
             beats_sent, clears_sent, settings_used);
    $display("%0d results compared across free-running, idle, stalled and held-off traffic.",
             compared);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- pid_with_clamped_terms.f -----
+incdir+hw/rtl
hw/rtl/pidct_pkg.sv
hw/rtl/pidct_in_if.sv
hw/rtl/pidct_out_if.sv
hw/rtl/pidct_term.sv
hw/rtl/pid_with_clamped_terms.sv
hw/rtl/pidct_chk.sv
tb/sv/pidct_tb_pkg.sv
tb/sv/pid_term_checker.sv
tb/sv/tb_pid_with_clamped_terms.sv
